@@ hdl/flood_leader_election_node_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the flood leader election node
// Concurrent assertion wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FLOOD_LEADER_ELECTION_NODE_CORE_DEFINES_SVH
`define FLOOD_LEADER_ELECTION_NODE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FLNE_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define FLNE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FLNE_ASSERT_SAME(name, ante, cons, msg)
`define FLNE_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

@@ hdl/flne_pkg.sv @@
// ----------------------------------------------------------------------------
// flne_pkg
// Types, codes and sizes shared by the flood leader election node.
// ----------------------------------------------------------------------------
package flne_pkg;

  localparam int MAX_NB      = 8;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int UID_W       = 16;
  localparam int ROUND_W     = 16;
  localparam int DIST_W      = 8;
  localparam int STAT_W      = 2;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_FLOOD = 2'd0,
    OP_TERM  = 2'd1,
    OP_START = 2'd2
  } op_t;

  localparam logic [STAT_W-1:0] ST_UNKNOWN    = 2'd0;
  localparam logic [STAT_W-1:0] ST_LEADER     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NON_LEADER = 2'd2;

  localparam logic KIND_FLOOD = 1'b0;
  localparam logic KIND_TERM  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MY_UID   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NB_COUNT = 4'd1;

  localparam logic [7:0] STABLE_LIMIT = 8'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UID,
    S_DIST,
    S_LEAD,
    S_RECORD,
    S_SCAN_ISSUE,
    S_SCAN,
    S_ADV,
    S_ROUND,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

  typedef struct packed {
    logic               valid;
    logic [ROUND_W-1:0] round;
  } nb_entry_t;

endpackage

@@ hdl/flne_cmp.sv @@
// ----------------------------------------------------------------------------
// flne_cmp
// Shared 16-bit unsigned magnitude comparator used by the decode, UID, distance, leader, scan and round steps.
// ----------------------------------------------------------------------------
module flne_cmp (
  input  logic [flne_pkg::UID_W-1:0] a,
  input  logic [flne_pkg::UID_W-1:0] b,
  output flne_pkg::cmp_res_t         res
);
  import flne_pkg::*;

  assign res.gt = (a > b);
  assign res.eq = (a == b);

endmodule

@@ hdl/flne_nbr_table.sv @@
// ----------------------------------------------------------------------------
// flne_nbr_table
// Per-neighbour round record: valid flags in flops, rounds in a small
// memory with one write and one registered read port.
// ----------------------------------------------------------------------------
module flne_nbr_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         wr_en,
  input  logic [flne_pkg::IDX_W-1:0]   wr_addr,
  input  logic [flne_pkg::ROUND_W-1:0] wr_round,
  input  logic [flne_pkg::IDX_W-1:0]   rd_addr,
  output flne_pkg::nb_entry_t          rd_entry
);
  import flne_pkg::*;

  logic [MAX_NB-1:0]  valid;
  logic [ROUND_W-1:0] mem [MAX_NB];

  // A cleared flag hides whatever round is left in the memory.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_round;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry.valid <= valid[rd_addr];
    rd_entry.round <= mem[rd_addr];
  end

endmodule

@@ hdl/flood_leader_election_node_core.sv @@
// ----------------------------------------------------------------------------
// flood_leader_election_node_core
// One node of flood-based leader election, one message word at a time.
// A start word reinitializes the node and sends its first flood. A flood
// word from a neighbour updates the best UID, its distance, the largest
// distance and a stability count; the node then either declares itself
// leader and sends a terminate, or records the neighbour's round, advances
// its own round and sends a flood. A terminate word makes an undecided node
// a non-leader and relays it. The node works on one word at a time:
// s_axis_tready is high only while it is idle. A start or terminate goes
// from decode to emit; a flood that wins leadership passes UID, distance and
// leader; an ordinary flood goes on to record, scan, advance, round and emit,
// its scan reading at most the effective neighbour count of entries, as the
// check that all neighbour rounds are equal reads the round table one entry
// per cycle through its single read port and compares each entry against
// entry 0 on the one shared comparator. A word with no result frees the node.
// The finished result sits in an output register, so the node stalls only if a
// second result is ready before the first has been taken. Configuration
// writes are always accepted and are meant to happen while the node idles.
// ----------------------------------------------------------------------------
`include "flood_leader_election_node_core_defines.svh"

module flood_leader_election_node_core (
  input  logic                                clk,
  input  logic                                rst,
  // Input words.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0 up: neighbour[2:0], msg_round[18:3], msg_max_uid[34:19],
  // msg_dist[42:35], msg_max_dist[50:43], zero padding[55:51].
  input  logic [flne_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0 up: op[1:0].
  input  logic [flne_pkg::OP_W-1:0]           s_axis_tuser,
  // Result words.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0 up: out_round[15:0], src_uid[31:16], out_max_uid[47:32],
  // out_dist[55:48], out_max_dist[63:56], leader_status[65:64],
  // zero padding[71:66].
  output logic [flne_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0 up: kind[0].
  output logic [0:0]                          m_axis_tuser,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [flne_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [flne_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import flne_pkg::*;

  state_t state, state_next;

  // Configuration registers.
  logic [UID_W-1:0] my_uid;
  logic [CNT_W-1:0] nb_count;

  // Captured input word.
  logic [OP_W-1:0]    it_op;
  logic [IDX_W-1:0]   it_idx;
  logic [ROUND_W-1:0] it_round;
  logic [UID_W-1:0]   it_uid;
  logic [DIST_W-1:0]  it_dist;
  logic [DIST_W-1:0]  it_mdist;

  // Election state.
  logic [UID_W-1:0]   best_uid;
  logic [DIST_W-1:0]  dist_to_best;
  logic [DIST_W-1:0]  largest_dist;
  logic [7:0]         stable_count;
  logic [ROUND_W-1:0] node_round;
  logic [STAT_W-1:0]  node_status;

  // Per-word scratch.
  logic               rec;
  logic               differ;
  logic               all_eq;
  logic [IDX_W-1:0]   scan_idx;
  logic               ref_valid;
  logic [ROUND_W-1:0] ref_round;
  logic               em_kind;
  logic [ROUND_W-1:0] em_round;

  // Output register.
  logic                   out_valid;
  logic                   out_kind;
  logic [ROUND_W-1:0]     out_round;
  logic [UID_W-1:0]       out_src;
  logic [UID_W-1:0]       out_uid;
  logic [DIST_W-1:0]      out_dist;
  logic [DIST_W-1:0]      out_mdist;
  logic [STAT_W-1:0]      out_status;

  // Shared comparator and table connections.
  logic [UID_W-1:0]   cmp_a;
  logic [UID_W-1:0]   cmp_b;
  cmp_res_t           cmp;
  logic               tbl_clear;
  logic               tbl_wr;
  logic [IDX_W-1:0]   tbl_rd_addr;
  nb_entry_t          rd;

  logic               in_acc;
  logic               out_free;
  logic [CNT_W-1:0]   eff_count;
  logic               idx_ok;
  logic               rec_now;
  logic               uid_lt;
  logic               leader_now;
  logic               scan_last;
  logic               mismatch;
  logic [DIST_W-1:0]  dist_new;
  logic [7:0]         stable_inc;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign cfg_ready     = 1'b1;

  // A count of zero acts as one neighbour, an oversized count as the table depth.
  always_comb begin
    if (nb_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (nb_count > CNT_W'(MAX_NB)) begin
      eff_count = CNT_W'(MAX_NB);
    end else begin
      eff_count = nb_count;
    end
  end

  assign idx_ok     = ({1'b0, it_idx} < eff_count);
  assign rec_now    = !rd.valid || cmp.gt;
  assign uid_lt     = !cmp.gt && !cmp.eq;
  assign leader_now = cmp.eq && (stable_count > STABLE_LIMIT);
  assign scan_last  = ({1'b0, scan_idx} == (eff_count - CNT_W'(1)));
  assign mismatch   = (rd.valid != ref_valid) || (rd.valid && !cmp.eq);
  assign dist_new   = (it_dist == {DIST_W{1'b1}}) ? it_dist : it_dist + DIST_W'(1);
  assign stable_inc = (stable_count == 8'hFF) ? stable_count : stable_count + 8'd1;

  flne_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  flne_nbr_table u_table (
    .clk      (clk),
    .rst      (rst),
    .clear    (tbl_clear),
    .wr_en    (tbl_wr),
    .wr_addr  (it_idx),
    .wr_round (it_round),
    .rd_addr  (tbl_rd_addr),
    .rd_entry (rd)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (it_op)
          OP_START: state_next = S_EMIT;
          OP_TERM: begin
            if (idx_ok && (node_status == ST_UNKNOWN)) state_next = S_EMIT;
            else state_next = S_IDLE;
          end
          OP_FLOOD: begin
            if (idx_ok) state_next = S_UID;
            else state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_UID: begin
        if (cmp.gt) state_next = S_RECORD;
        else if (cmp.eq) state_next = S_DIST;
        else state_next = S_IDLE;
      end
      S_DIST: begin
        if (cmp.eq && differ) state_next = S_LEAD;
        else state_next = S_RECORD;
      end
      S_LEAD: begin
        if (leader_now) state_next = S_EMIT;
        else state_next = S_RECORD;
      end
      S_RECORD:     state_next = S_SCAN_ISSUE;
      S_SCAN_ISSUE: state_next = S_SCAN;
      S_SCAN: begin
        if ((scan_idx != '0 && mismatch) || scan_last) state_next = S_ADV;
      end
      S_ADV:   state_next = S_ROUND;
      S_ROUND: state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Comparator operands, table access and write strobes for each step.
  always_comb begin
    cmp_a       = '0;
    cmp_b       = '0;
    tbl_clear   = 1'b0;
    tbl_wr      = 1'b0;
    tbl_rd_addr = '0;
    case (state)
      S_IDLE: begin
        tbl_rd_addr = s_axis_tdata[IDX_W-1:0];
      end
      S_DECODE: begin
        cmp_a     = it_round;
        cmp_b     = rd.round;
        tbl_clear = (it_op == OP_START);
        tbl_wr    = (it_op == OP_TERM) && idx_ok && rec_now;
      end
      S_UID: begin
        cmp_a  = it_uid;
        cmp_b  = best_uid;
        tbl_wr = uid_lt && rec;
      end
      S_DIST: begin
        // Equality is symmetric; gt here means the sender knows a longer path.
        cmp_a = {{(UID_W-DIST_W){1'b0}}, it_mdist};
        cmp_b = {{(UID_W-DIST_W){1'b0}}, largest_dist};
      end
      S_LEAD: begin
        cmp_a  = my_uid;
        cmp_b  = best_uid;
        tbl_wr = leader_now && rec;
      end
      S_RECORD: begin
        tbl_wr = rec;
      end
      S_SCAN_ISSUE: begin
        tbl_rd_addr = '0;
      end
      S_SCAN: begin
        cmp_a       = rd.round;
        cmp_b       = ref_round;
        tbl_rd_addr = scan_idx + IDX_W'(1);
      end
      S_ROUND: begin
        cmp_a = it_round;
        cmp_b = node_round;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      my_uid   <= '0;
      nb_count <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MY_UID:   my_uid   <= cfg_data;
        REG_NB_COUNT: nb_count <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Captured word fields.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      it_op    <= s_axis_tuser;
      it_idx   <= s_axis_tdata[2:0];
      it_round <= s_axis_tdata[18:3];
      it_uid   <= s_axis_tdata[34:19];
      it_dist  <= s_axis_tdata[42:35];
      it_mdist <= s_axis_tdata[50:43];
    end
  end

  // Election state.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_uid     <= '0;
      dist_to_best <= '0;
      largest_dist <= '0;
      stable_count <= 8'd1;
      node_round   <= '0;
      node_status  <= ST_UNKNOWN;
    end else begin
      case (state)
        S_DECODE: begin
          if (it_op == OP_START) begin
            best_uid     <= my_uid;
            dist_to_best <= '0;
            largest_dist <= '0;
            stable_count <= 8'd1;
            node_round   <= '0;
            node_status  <= ST_UNKNOWN;
          end else if ((it_op == OP_TERM) && idx_ok && (node_status == ST_UNKNOWN)) begin
            node_status <= ST_NON_LEADER;
          end
        end
        S_UID: begin
          if (cmp.gt) begin
            best_uid     <= it_uid;
            dist_to_best <= dist_new;
            largest_dist <= dist_new;
            stable_count <= 8'd1;
          end
        end
        S_DIST: begin
          if (cmp.eq && differ) begin
            stable_count <= stable_inc;
          end else if (cmp.gt) begin
            largest_dist <= it_mdist;
            stable_count <= 8'd1;
          end
        end
        S_LEAD: begin
          if (leader_now) begin
            node_status <= ST_LEADER;
            node_round  <= node_round + ROUND_W'(1);
          end
        end
        S_ADV: begin
          if (all_eq) node_round <= node_round + ROUND_W'(1);
        end
        S_ROUND: begin
          if (cmp.gt) node_round <= it_round;
        end
        default: begin
        end
      endcase
    end
  end

  // Per-word scratch: round-record decision, round scan and the pending message.
  always_ff @(posedge clk) begin
    case (state)
      S_DECODE: begin
        rec      <= rec_now;
        differ   <= !rd.valid || !cmp.eq;
        em_kind  <= (it_op == OP_START) ? KIND_FLOOD : KIND_TERM;
        em_round <= (it_op == OP_START) ? '0 : node_round;
      end
      S_LEAD: begin
        // The terminate carries the round from before the increment.
        em_kind  <= KIND_TERM;
        em_round <= node_round;
      end
      S_SCAN_ISSUE: begin
        scan_idx <= '0;
        all_eq   <= 1'b1;
      end
      S_SCAN: begin
        if (scan_idx == '0) begin
          ref_valid <= rd.valid;
          ref_round <= rd.round;
        end else if (mismatch) begin
          all_eq <= 1'b0;
        end
        scan_idx <= scan_idx + IDX_W'(1);
      end
      S_ROUND: begin
        em_kind  <= KIND_FLOOD;
        em_round <= cmp.gt ? it_round : node_round;
      end
      default: begin
      end
    endcase
  end

  // Output register; a new result loads as soon as the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_kind   <= em_kind;
      out_round  <= em_round;
      out_src    <= my_uid;
      out_uid    <= best_uid;
      out_dist   <= dist_to_best;
      out_mdist  <= largest_dist;
      out_status <= node_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {6'b0, out_status, out_mdist, out_dist, out_uid, out_src, out_round};

  // A terminate is only ever sent by a node that has decided.
  `FLNE_ASSERT_SAME(a_term_decided, out_valid && (out_kind == KIND_TERM),
    out_status != ST_UNKNOWN, "terminate sent by an undecided node")
  // A decision sticks until the next start.
  `FLNE_ASSERT_NEXT(a_status_sticky,
    (node_status != ST_UNKNOWN) && !((state == S_DECODE) && (it_op == OP_START)),
    node_status != ST_UNKNOWN, "decided node fell back to unknown")
  // A start leaves the node in its initial state.
  `FLNE_ASSERT_NEXT(a_start_init, (state == S_DECODE) && (it_op == OP_START),
    (node_round == '0) && (node_status == ST_UNKNOWN) && (stable_count == 8'd1)
      && (best_uid == my_uid), "start did not reinitialize the node")
  // The round scan never walks past the neighbours in use.
  `FLNE_ASSERT_SAME(a_scan_range, state == S_SCAN,
    {1'b0, scan_idx} < eff_count, "round scan beyond the neighbour count")

endmodule
